>>> rtl/mf3_pkg.sv
// Shared types, constants and a helper function of the 3x3 RGB median filter.
`default_nettype none
package mf3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int FW_W       = 11;
    localparam int FH_W       = 16;
    localparam int ROW_W      = FH_W + 1;
    localparam int PIX_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 16'd480;

    localparam logic MODE_FLUSH = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } mf3_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_last;
    } mf3_out_t;

    typedef logic [8:0][7:0] chan9_t;

    function automatic chan9_t cmp_swap(chan9_t p, logic [3:0] a, logic [3:0] b);
        chan9_t q;
        q = p;
        if (p[a] > p[b]) begin
            q[a] = p[b];
            q[b] = p[a];
        end
        return q;
    endfunction

endpackage
`default_nettype wire

>>> rtl/mf3_line_ram.sv
// Line store memory holding the upper and lower line side by side, one read and one write port.
`default_nettype none
module mf3_line_ram (
    input  wire logic                        aclk,
    input  wire logic                        wr_en,
    input  wire logic [mf3_pkg::COL_W-1:0]   wr_addr,
    input  wire logic [2*mf3_pkg::PIX_W-1:0] wr_data,
    input  wire logic                        rd_en,
    input  wire logic [mf3_pkg::COL_W-1:0]   rd_addr,
    output logic      [2*mf3_pkg::PIX_W-1:0] rd_data
);

    logic [2*mf3_pkg::PIX_W-1:0] mem [mf3_pkg::MAX_WIDTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/mf3_median9.sv
// Three-stage pipelined median-of-nine network for one color channel.
`default_nettype none
module mf3_median9 (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire mf3_pkg::chan9_t vals,
    output logic [7:0]           med
);

    mf3_pkg::chan9_t a_comb, b_comb, c_comb;
    mf3_pkg::chan9_t s1_reg, s2_reg;

    always_comb begin
        a_comb = vals;
        a_comb = mf3_pkg::cmp_swap(a_comb, 4'd1, 4'd2);
        a_comb = mf3_pkg::cmp_swap(a_comb, 4'd4, 4'd5);
        a_comb = mf3_pkg::cmp_swap(a_comb, 4'd7, 4'd8);
        a_comb = mf3_pkg::cmp_swap(a_comb, 4'd0, 4'd1);
        a_comb = mf3_pkg::cmp_swap(a_comb, 4'd3, 4'd4);
        a_comb = mf3_pkg::cmp_swap(a_comb, 4'd6, 4'd7);
        a_comb = mf3_pkg::cmp_swap(a_comb, 4'd1, 4'd2);
        a_comb = mf3_pkg::cmp_swap(a_comb, 4'd4, 4'd5);
        a_comb = mf3_pkg::cmp_swap(a_comb, 4'd7, 4'd8);
    end

    always_comb begin
        b_comb = s1_reg;
        b_comb = mf3_pkg::cmp_swap(b_comb, 4'd0, 4'd3);
        b_comb = mf3_pkg::cmp_swap(b_comb, 4'd5, 4'd8);
        b_comb = mf3_pkg::cmp_swap(b_comb, 4'd4, 4'd7);
        b_comb = mf3_pkg::cmp_swap(b_comb, 4'd3, 4'd6);
        b_comb = mf3_pkg::cmp_swap(b_comb, 4'd1, 4'd4);
        b_comb = mf3_pkg::cmp_swap(b_comb, 4'd2, 4'd5);
    end

    always_comb begin
        c_comb = s2_reg;
        c_comb = mf3_pkg::cmp_swap(c_comb, 4'd4, 4'd7);
        c_comb = mf3_pkg::cmp_swap(c_comb, 4'd4, 4'd2);
        c_comb = mf3_pkg::cmp_swap(c_comb, 4'd6, 4'd4);
        c_comb = mf3_pkg::cmp_swap(c_comb, 4'd4, 4'd2);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg <= a_comb;
            s2_reg <= b_comb;
            med    <= c_comb[4];
        end
    end

endmodule
`default_nettype wire

>>> rtl/median_filter_3x3_rgb_top.sv
// Top level of the 3x3 RGB median filter: position control, line store access, window and output.
// The filter takes one item per clock and delivers results at the same rate while m_ready does not
// stall it; the line store is a single memory read and written once per item, with the write of
// the previous item forwarded when both fall on the same column. A result for a frame position is
// caused by the item that enters frame_width + 1 items after that pixel, and it passes through the
// memory read at the edge that accepts the causing item, then the window, the padding stage and the
// three-stage sorting network. After the last pixel of a frame, frame_width + 1 flush items drain
// the remaining results. The line store needs no clearing pass.
`default_nettype none
module median_filter_3x3_rgb_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire mf3_pkg::mf3_in_t                  s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output mf3_pkg::mf3_out_t                      m_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mf3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mf3_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int COL_W = mf3_pkg::COL_W;
    localparam int FW_W  = mf3_pkg::FW_W;
    localparam int FH_W  = mf3_pkg::FH_W;
    localparam int ROW_W = mf3_pkg::ROW_W;
    localparam int PIX_W = mf3_pkg::PIX_W;

    logic [FW_W-1:0]  frame_width_reg;
    logic [FH_W-1:0]  frame_height_reg;
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [FH_W-1:0]  out_row_reg, out_row_next;

    logic [FW_W-1:0]  w_eff;
    logic [FH_W-1:0]  h_eff;
    logic             en, accept, take, draining, flush, due, col_zero, wrap, last;
    logic             cfg_accept;
    logic [FW_W-1:0]  col_inc;
    logic [8:0]       mask;
    logic [3:0]       n_cnt;
    logic [2:0]       zero_cnt;
    logic             up_ok, down_ok, left_ok, right_ok;
    logic [PIX_W-1:0] pix;

    logic                  p1_valid_reg, p1_due_reg, p1_last_reg, p1_fwd_reg;
    logic [PIX_W-1:0]      p1_pix_reg, fwd_top_reg, fwd_mid_reg;
    logic [COL_W-1:0]      p1_col_reg;
    logic [8:0]            p1_mask_reg;
    logic [2:0]            p1_zero_reg;
    logic [2*PIX_W-1:0]    rd_data;
    logic [PIX_W-1:0]      top_eff, mid_eff;

    logic [PIX_W-1:0]      window_reg [9];
    logic                  p2_valid_reg, p2_last_reg;
    logic [8:0]            p2_mask_reg;
    logic [2:0]            p2_zero_reg;
    logic [PIX_W-1:0]      padded [9];
    mf3_pkg::chan9_t       r_comb, g_comb, b_comb;
    mf3_pkg::chan9_t       s0_r_reg, s0_g_reg, s0_b_reg;
    logic                  s0_valid_reg, s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic                  s0_last_reg, s1_last_reg, s2_last_reg, out_last_reg;
    logic [7:0]            med_r, med_g, med_b;

    assign en         = !out_valid_reg || m_ready;
    assign s_ready    = en;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign accept     = s_valid && s_ready;

    always_comb begin
        if (frame_width_reg == '0) begin
            w_eff = FW_W'(1);
        end else if (frame_width_reg > FW_W'(mf3_pkg::MAX_WIDTH)) begin
            w_eff = FW_W'(mf3_pkg::MAX_WIDTH);
        end else begin
            w_eff = frame_width_reg;
        end
        h_eff = (frame_height_reg == '0) ? FH_W'(1) : frame_height_reg;
    end

    always_comb begin
        draining = in_row_reg >= {1'b0, h_eff};
        flush    = s_data.mode == mf3_pkg::MODE_FLUSH;
        take     = accept && !(flush && !draining);
        col_zero = in_col_reg == '0;
        due      = (in_row_reg >= ROW_W'(2)) || ((in_row_reg == ROW_W'(1)) && !col_zero);
        col_inc  = {1'b0, in_col_reg} + FW_W'(1);
        wrap     = col_inc >= w_eff;
        last     = (({1'b0, out_col_reg} + FW_W'(1)) >= w_eff)
                   && (({1'b0, out_row_reg} + ROW_W'(1)) >= {1'b0, h_eff});
        up_ok    = out_row_reg != '0;
        down_ok  = ({1'b0, out_row_reg} + ROW_W'(1)) < {1'b0, h_eff};
        left_ok  = out_col_reg != '0;
        right_ok = (({1'b0, out_col_reg} + FW_W'(1)) < w_eff) && !col_zero;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                mask[r*3+c] = ((r != 0) || up_ok) && ((r != 2) || down_ok)
                              && ((c != 0) || left_ok) && ((c != 2) || right_ok);
            end
        end
        n_cnt = '0;
        for (int i = 0; i < 9; i++) begin
            n_cnt = n_cnt + {3'b000, mask[i]};
        end
        zero_cnt = 3'd4 - n_cnt[3:1];
        pix      = draining ? '0 : {s_data.red_in, s_data.green_in, s_data.blue_in};
    end

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_accept) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end else if (take) begin
            if (wrap) begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end else begin
                in_col_next = col_inc[COL_W-1:0];
            end
            if (due) begin
                if (last) begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end else if (({1'b0, out_col_reg} + FW_W'(1)) >= w_eff) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + FH_W'(1);
                end else begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= mf3_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= mf3_pkg::FRAME_HEIGHT_RESET;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
        end else begin
            if (cfg_accept && cfg_index == mf3_pkg::CFG_FRAME_WIDTH) begin
                frame_width_reg <= cfg_data[FW_W-1:0];
            end
            if (cfg_accept && cfg_index == mf3_pkg::CFG_FRAME_HEIGHT) begin
                frame_height_reg <= cfg_data[FH_W-1:0];
            end
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    assign top_eff = p1_fwd_reg ? fwd_top_reg : rd_data[2*PIX_W-1:PIX_W];
    assign mid_eff = p1_fwd_reg ? fwd_mid_reg : rd_data[PIX_W-1:0];

    mf3_line_ram u_line_ram (
        .aclk    (aclk),
        .wr_en   (en && p1_valid_reg),
        .wr_addr (p1_col_reg),
        .wr_data ({mid_eff, p1_pix_reg}),
        .rd_en   (take),
        .rd_addr (in_col_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p1_fwd_reg    <= 1'b0;
            p2_valid_reg  <= 1'b0;
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                window_reg[i] <= '0;
            end
        end else if (en) begin
            p1_valid_reg  <= take;
            p1_fwd_reg    <= take && p1_valid_reg && (p1_col_reg == in_col_reg);
            p2_valid_reg  <= p1_valid_reg && p1_due_reg;
            s0_valid_reg  <= p2_valid_reg;
            s1_valid_reg  <= s0_valid_reg;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
            if (p1_valid_reg) begin
                for (int r = 0; r < 3; r++) begin
                    window_reg[r*3]   <= window_reg[r*3+1];
                    window_reg[r*3+1] <= window_reg[r*3+2];
                end
                window_reg[2] <= top_eff;
                window_reg[5] <= mid_eff;
                window_reg[8] <= p1_pix_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_pix_reg   <= pix;
            p1_col_reg   <= in_col_reg;
            p1_due_reg   <= due;
            p1_last_reg  <= last;
            p1_mask_reg  <= mask;
            p1_zero_reg  <= zero_cnt;
            fwd_top_reg  <= mid_eff;
            fwd_mid_reg  <= p1_pix_reg;
            p2_last_reg  <= p1_last_reg;
            p2_mask_reg  <= p1_mask_reg;
            p2_zero_reg  <= p1_zero_reg;
            s0_r_reg     <= r_comb;
            s0_g_reg     <= g_comb;
            s0_b_reg     <= b_comb;
            s0_last_reg  <= p2_last_reg;
            s1_last_reg  <= s0_last_reg;
            s2_last_reg  <= s1_last_reg;
            out_last_reg <= s2_last_reg;
        end
    end

    // Missing neighbors are padded with zeros and full-scale values so that the middle of
    // nine lands on the upper median of the neighbors that are present.
    always_comb begin
        logic [3:0] rank;
        rank = '0;
        for (int i = 0; i < 9; i++) begin
            if (p2_mask_reg[i]) begin
                padded[i] = window_reg[i];
            end else if (rank < {1'b0, p2_zero_reg}) begin
                padded[i] = '0;
            end else begin
                padded[i] = '1;
            end
            rank = rank + {3'b000, !p2_mask_reg[i]};
        end
        for (int i = 0; i < 9; i++) begin
            r_comb[i] = padded[i][23:16];
            g_comb[i] = padded[i][15:8];
            b_comb[i] = padded[i][7:0];
        end
    end

    mf3_median9 u_med_r (.aclk(aclk), .en(en), .vals(s0_r_reg), .med(med_r));
    mf3_median9 u_med_g (.aclk(aclk), .en(en), .vals(s0_g_reg), .med(med_g));
    mf3_median9 u_med_b (.aclk(aclk), .en(en), .vals(s0_b_reg), .med(med_b));

    assign m_valid           = out_valid_reg;
    assign m_data.red_out    = med_r;
    assign m_data.green_out  = med_g;
    assign m_data.blue_out   = med_b;
    assign m_data.frame_last = out_last_reg;

endmodule
`default_nettype wire
